FILE: hdl/svt_pkg.sv
package svt_pkg;

   localparam int CNT_W = 18;
   localparam int EXT_W = 7;
   localparam int CRD_W = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_Z = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [EXT_W-1:0] EXT_RESET = 7'd64;
   localparam logic [EXT_W-1:0] EXT_MIN   = 7'd2;

   typedef struct packed {
      logic             command;
      logic             occupied;
      logic [CRD_W-1:0] lo_x;
      logic [CRD_W-1:0] lo_y;
      logic [CRD_W-1:0] lo_z;
      logic [CRD_W-1:0] hi_x;
      logic [CRD_W-1:0] hi_y;
      logic [CRD_W-1:0] hi_z;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] box_count;
      logic             bad_query;
   } rsp_type;

   typedef struct packed {
      logic init;
      logic init_val;
      logic acc_en;
      logic subtract;
      logic zero;
   } alu_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/svt_ram.sv
module svt_ram import svt_pkg::*; #(
   parameter int AW = 18
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [CNT_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [CNT_W-1:0] rd_data
);

   logic [CNT_W-1:0] mem [0:(1<<AW)-1];
   logic [CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/svt_alu.sv
module svt_alu import svt_pkg::*; (
   input  logic             clock,
   input  alu_ctrl_type     ctl,
   input  logic [CNT_W-1:0] rd_data,
   output logic [CNT_W-1:0] acc
);

   logic [CNT_W-1:0] acc_ff;
   logic [CNT_W-1:0] acc_in;
   logic [CNT_W-1:0] opnd;

   assign opnd = ctl.zero ? '0 : rd_data;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.init) begin
         acc_in = {{(CNT_W-1){1'b0}}, ctl.init_val};
      end else if (ctl.acc_en) begin
         acc_in = ctl.subtract ? (acc_ff - opnd) : (acc_ff + opnd);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: hdl/svt_ctrl.sv
module svt_ctrl import svt_pkg::*; #(
   parameter int PW = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  req_type            req_data,
   output logic               req_stall,
   input  logic [EXT_W-1:0]   ext_x,
   input  logic [EXT_W-1:0]   ext_y,
   input  logic [EXT_W-1:0]   ext_z,
   input  logic               rsp_free,
   output logic [3*PW-1:0]    mem_rd_addr,
   output logic               mem_wr_en,
   output logic [3*PW-1:0]    mem_wr_addr,
   output alu_ctrl_type       alu_ctl,
   output logic               rsp_load,
   output logic               rsp_bad
);

   localparam int CW = ((PW > EXT_W) ? PW : EXT_W) + 1;

   state_type       state_ff, state_in;
   logic [2:0]      k_ff, k_in;
   logic            load_ff, load_in;
   logic            bad_ff, bad_in;
   logic [PW-1:0]   a_x_ff, a_y_ff, a_z_ff, a_x_in, a_y_in, a_z_in;
   logic [PW-1:0]   b_x_ff, b_y_ff, b_z_ff, b_x_in, b_y_in, b_z_in;
   logic [PW-1:0]   pos_x_ff, pos_y_ff, pos_z_ff, pos_x_in, pos_y_in, pos_z_in;
   logic            rd_en_ff, rd_en_in;
   logic            rd_sub_ff, rd_sub_in;
   logic            rd_zero_ff, rd_zero_in;

   logic            accept;
   logic            is_load;
   logic            pos_zero;
   logic            bad_q;
   logic            x_wrap, y_wrap, z_wrap;
   logic [PW-1:0]   c_x, c_y, c_z;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign is_load  = (req_data.command == CMD_LOAD);
   assign pos_zero = (pos_x_ff == '0) || (pos_y_ff == '0) || (pos_z_ff == '0);

   assign bad_q = (req_data.lo_x > req_data.hi_x) || (req_data.lo_y > req_data.hi_y) ||
                  (req_data.lo_z > req_data.hi_z) ||
                  ({1'b0, req_data.hi_x} >= ext_x) || ({1'b0, req_data.hi_y} >= ext_y) ||
                  ({1'b0, req_data.hi_z} >= ext_z);

   assign x_wrap = (CW'(pos_x_ff) + CW'(1)) >= CW'(ext_x);
   assign y_wrap = (CW'(pos_y_ff) + CW'(1)) >= CW'(ext_y);
   assign z_wrap = (CW'(pos_z_ff) + CW'(1)) >= CW'(ext_z);

   // corner select: bit 2 x, bit 1 y, bit 0 z; set bit picks the low/minus-one side
   assign c_x = k_ff[2] ? b_x_ff : a_x_ff;
   assign c_y = k_ff[1] ? b_y_ff : a_y_ff;
   assign c_z = k_ff[0] ? b_z_ff : a_z_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_load) begin
                  state_in = pos_zero ? ST_IDLE : ST_READ;
               end else begin
                  state_in = bad_q ? ST_DONE : ST_READ;
               end
            end
         end
         ST_READ: begin
            if (k_ff == 3'd7) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = load_ff ? ST_WRITE : ST_DONE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      mem_rd_addr      = {c_z, c_y, c_x};
      mem_wr_en        = (state_ff == ST_WRITE);
      mem_wr_addr      = {a_z_ff, a_y_ff, a_x_ff};
      alu_ctl.init     = accept;
      alu_ctl.init_val = req_data.occupied && is_load;
      alu_ctl.acc_en   = rd_en_ff;
      alu_ctl.subtract = rd_sub_ff;
      alu_ctl.zero     = rd_zero_ff;
      rsp_load         = (state_ff == ST_DONE) && rsp_free;
      rsp_bad          = bad_ff;
   end

   always_comb begin
      k_in       = k_ff;
      load_in    = load_ff;
      bad_in     = bad_ff;
      a_x_in     = a_x_ff;
      a_y_in     = a_y_ff;
      a_z_in     = a_z_ff;
      b_x_in     = b_x_ff;
      b_y_in     = b_y_ff;
      b_z_in     = b_z_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      pos_z_in   = pos_z_ff;
      rd_en_in   = 1'b0;
      rd_sub_in  = ^k_ff ^ load_ff;
      rd_zero_in = (c_x == '0) || (c_y == '0) || (c_z == '0);
      if (accept) begin
         load_in = is_load;
         bad_in  = !is_load && bad_q;
         if (is_load) begin
            k_in   = 3'd1;
            a_x_in = pos_x_ff;
            a_y_in = pos_y_ff;
            a_z_in = pos_z_ff;
            b_x_in = pos_x_ff - PW'(1);
            b_y_in = pos_y_ff - PW'(1);
            b_z_in = pos_z_ff - PW'(1);
            if (x_wrap) begin
               pos_x_in = '0;
               if (y_wrap) begin
                  pos_y_in = '0;
                  pos_z_in = z_wrap ? '0 : (pos_z_ff + PW'(1));
               end else begin
                  pos_y_in = pos_y_ff + PW'(1);
               end
            end else begin
               pos_x_in = pos_x_ff + PW'(1);
            end
         end else begin
            k_in   = 3'd0;
            a_x_in = PW'(req_data.hi_x);
            a_y_in = PW'(req_data.hi_y);
            a_z_in = PW'(req_data.hi_z);
            b_x_in = PW'(req_data.lo_x);
            b_y_in = PW'(req_data.lo_y);
            b_z_in = PW'(req_data.lo_z);
         end
      end
      if (state_ff == ST_READ) begin
         rd_en_in = 1'b1;
         k_in     = k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         rd_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
         rd_en_ff <= rd_en_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      load_ff    <= load_in;
      bad_ff     <= bad_in;
      a_x_ff     <= a_x_in;
      a_y_ff     <= a_y_in;
      a_z_ff     <= a_z_in;
      b_x_ff     <= b_x_in;
      b_y_ff     <= b_y_in;
      b_z_ff     <= b_z_in;
      rd_sub_ff  <= rd_sub_in;
      rd_zero_ff <= rd_zero_in;
   end

endmodule

FILE: hdl/summed_volume_table_box_count_top.sv
// Channel  Ports                            Dir  Word
// req      req_valid req_stall req_data     in   req_type: command, occupied, lo/hi corners
// rsp      rsp_valid rsp_stall rsp_data     out  rsp_type: box_count, bad_query
// csr      csr_valid csr_ready csr_index    in   csr_data: extent_x/y/z by index 0..2
//
// Load word: 7 table reads, drain, write; an index-0 voxel is taken with no reads and no write.
// Query word: 8 table reads, drain, result; a query flagged bad goes straight to the result.
// The table has a single read port feeding one shared add/subtract accumulator.
// Reset is synchronous: position to origin, extents to 64, table contents left as is.
// A pending result waits in the output register; a stalled result holds the next query at done.
module summed_volume_table_box_count_top import svt_pkg::*; #(
   parameter int MAX_DIM = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EXT_W-1:0]     csr_data
);

   localparam int PW = $clog2(MAX_DIM);
   localparam int AW = 3 * PW;
   localparam int DW = ((PW > EXT_W) ? PW : EXT_W) + 2;

   logic [EXT_W-1:0] ext_x_ff, ext_y_ff, ext_z_ff;
   logic [EXT_W-1:0] ext_x_in, ext_y_in, ext_z_in;
   logic [EXT_W-1:0] eff_x, eff_y, eff_z;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_free;
   logic             rsp_load;
   logic             rsp_bad;
   logic [AW-1:0]    mem_rd_addr;
   logic [AW-1:0]    mem_wr_addr;
   logic             mem_wr_en;
   logic [CNT_W-1:0] mem_rd_data;
   logic [CNT_W-1:0] acc;
   alu_ctrl_type     alu_ctl;

   function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e);
      logic [EXT_W-1:0] r;
      r = e;
      if (e < EXT_MIN) begin
         r = EXT_MIN;
      end else if (DW'(e) > DW'(MAX_DIM)) begin
         r = EXT_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      ext_x_in = ext_x_ff;
      ext_y_in = ext_y_ff;
      ext_z_in = ext_z_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXTENT_X: ext_x_in = csr_data;
            CSR_EXTENT_Y: ext_y_in = csr_data;
            CSR_EXTENT_Z: ext_z_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   assign eff_x = clamp_ext(ext_x_ff);
   assign eff_y = clamp_ext(ext_y_ff);
   assign eff_z = clamp_ext(ext_z_ff);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.box_count = rsp_bad ? '0 : acc;
         rsp_data_in.bad_query = rsp_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_x_ff     <= EXT_RESET;
         ext_y_ff     <= EXT_RESET;
         ext_z_ff     <= EXT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ext_x_ff     <= ext_x_in;
         ext_y_ff     <= ext_y_in;
         ext_z_ff     <= ext_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   svt_ctrl #(
      .PW(PW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .ext_x       (eff_x),
      .ext_y       (eff_y),
      .ext_z       (eff_z),
      .rsp_free    (rsp_free),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .alu_ctl     (alu_ctl),
      .rsp_load    (rsp_load),
      .rsp_bad     (rsp_bad)
   );

   svt_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .rd_data (mem_rd_data),
      .acc     (acc)
   );

   svt_ram #(
      .AW(AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (acc),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_wr_nonzero: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((mem_wr_addr[PW-1:0] != '0) && (mem_wr_addr[2*PW-1:PW] != '0) &&
                     (mem_wr_addr[AW-1:2*PW] != '0)))
      else $error("table write at index-0 plane");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> req_stall)
      else $error("word accepted during table write");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_query) |-> (rsp_data.box_count == '0))
      else $error("flagged query with nonzero count");

endmodule
